// ===== rtl/hfd_pkg.sv =====
`default_nettype none

package hfd_pkg;

   // Longest frame, in characters including the start mark and the end mark.
   localparam int MaxFrameChars = 514;

   localparam logic [9:0] CharCountSat = 10'd1023;
   localparam logic [8:0] PayloadSat   = 9'd511;

   localparam logic [7:0] LrcStartReset        = 8'h00;
   localparam logic [7:0] PayloadCapacityReset = 8'hFF;

   // Configuration register indexes.
   localparam logic CsrLrcStart        = 1'b0;
   localparam logic CsrPayloadCapacity = 1'b1;

   // Result kinds.
   localparam logic KindData   = 1'b0;
   localparam logic KindStatus = 1'b1;

   typedef enum logic [2:0] {
      StatusOk          = 3'd0,
      StatusLrcMismatch = 3'd1,
      StatusOddLength   = 3'd2,
      StatusTooShort    = 3'd3,
      StatusOverflow    = 3'd4,
      StatusBadDigit    = 3'd5
   } status_type;

   typedef struct packed {
      logic       valid;
      logic       kind;
      logic [7:0] data_byte;
      status_type status;
   } hfd_result_type;

   typedef struct packed {
      logic [3:0] value;
      logic       bad;
   } hfd_nibble_type;

   // ASCII hex digit to nibble; anything else decodes as zero and is flagged.
   function automatic hfd_nibble_type hex_decode(input logic [7:0] c);
      hfd_nibble_type r;
      r.bad = 1'b0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r.value = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r.value = 4'(c - 8'h41 + 8'd10);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r.value = 4'(c - 8'h61 + 8'd10);
      end else begin
         r.value = 4'd0;
         r.bad   = 1'b1;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/hfd_frame_core.sv =====
`default_nettype none

module hfd_frame_core
   import hfd_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           advance,
   input  wire logic [7:0]     char_in,
   input  wire logic           frame_end,
   input  wire logic [7:0]     lrc_start,
   input  wire logic [7:0]     payload_capacity,
   output hfd_result_type      result
);

   logic [9:0] char_count_ff, char_count_in;
   logic [3:0] high_nibble_ff, high_nibble_in;
   logic [7:0] held_byte_ff, held_byte_in;
   logic       held_valid_ff, held_valid_in;
   logic [7:0] running_lrc_ff, running_lrc_in;
   logic [8:0] payload_count_ff, payload_count_in;
   logic       bad_digit_ff, bad_digit_in;

   hfd_nibble_type nib;
   logic [10:0]    frame_len;
   status_type     end_status;

   assign nib       = hex_decode(char_in);
   assign frame_len = {1'b0, char_count_ff} + 11'd1;

   // Checks in order of precedence; the first that applies wins.
   always_comb begin
      priority if (char_count_ff == CharCountSat) begin
         end_status = StatusOverflow;
      end else if (frame_len[0]) begin
         end_status = StatusOddLength;
      end else if (frame_len < 11'd4) begin
         end_status = StatusTooShort;
      end else if (frame_len > 11'(MaxFrameChars)) begin
         end_status = StatusOverflow;
      end else if (payload_count_ff > {1'b0, payload_capacity}) begin
         end_status = StatusOverflow;
      end else if (payload_count_ff == 9'd0) begin
         end_status = StatusTooShort;
      end else if (bad_digit_ff) begin
         end_status = StatusBadDigit;
      end else if (!held_valid_ff || held_byte_ff != running_lrc_ff) begin
         end_status = StatusLrcMismatch;
      end else begin
         end_status = StatusOk;
      end
   end

   always_comb begin
      char_count_in    = char_count_ff;
      high_nibble_in   = high_nibble_ff;
      held_byte_in     = held_byte_ff;
      held_valid_in    = held_valid_ff;
      running_lrc_in   = running_lrc_ff;
      payload_count_in = payload_count_ff;
      bad_digit_in     = bad_digit_ff;
      result.valid     = 1'b0;
      result.kind      = KindData;
      result.data_byte = 8'd0;
      result.status    = StatusOk;

      if (frame_end) begin
         result.valid     = 1'b1;
         result.kind      = KindStatus;
         result.status    = end_status;
         char_count_in    = 10'd0;
         high_nibble_in   = 4'd0;
         held_byte_in     = 8'd0;
         held_valid_in    = 1'b0;
         running_lrc_in   = 8'd0;
         payload_count_in = 9'd0;
         bad_digit_in     = 1'b0;
      end else begin
         if (char_count_ff != CharCountSat) begin
            char_count_in = char_count_ff + 10'd1;
         end
         if (char_count_ff == 10'd0) begin
            // Start mark: not decoded, just loads the LRC seed.
            running_lrc_in = lrc_start;
         end else begin
            bad_digit_in = bad_digit_ff | nib.bad;
            if (char_count_ff[0]) begin
               high_nibble_in = nib.value;
            end else begin
               // A pair completed: release the previously held byte.
               if (held_valid_ff) begin
                  if (payload_count_ff < {1'b0, payload_capacity}) begin
                     result.valid     = 1'b1;
                     result.data_byte = held_byte_ff;
                  end
                  running_lrc_in = running_lrc_ff - held_byte_ff;
                  if (payload_count_ff != PayloadSat) begin
                     payload_count_in = payload_count_ff + 9'd1;
                  end
               end
               held_byte_in  = {high_nibble_ff, nib.value};
               held_valid_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_count_ff    <= 10'd0;
         high_nibble_ff   <= 4'd0;
         held_byte_ff     <= 8'd0;
         held_valid_ff    <= 1'b0;
         running_lrc_ff   <= 8'd0;
         payload_count_ff <= 9'd0;
         bad_digit_ff     <= 1'b0;
      end else if (advance) begin
         char_count_ff    <= char_count_in;
         high_nibble_ff   <= high_nibble_in;
         held_byte_ff     <= held_byte_in;
         held_valid_ff    <= held_valid_in;
         running_lrc_ff   <= running_lrc_in;
         payload_count_ff <= payload_count_in;
         bad_digit_ff     <= bad_digit_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/hex_frame_decoder_lrc_check.sv =====
// Hex frame decoder with LRC check.
// The request channel (req_valid/req_ready) carries one frame character per
// request in req_char_in, with req_frame_end set on the frame's end character.
// The first character of each frame is a start mark and is skipped. After it,
// pairs of hex digits form bytes; the last pair is the LRC. Each released
// payload byte comes out on the response channel (rsp_valid/rsp_ready) with
// rsp_kind low; the end character produces one status response with rsp_kind
// high and a status code in rsp_status. Characters that complete no byte give
// no response.
// A request is captured in an input register and processed from there into the
// response register, so each response passes through both registers in turn.
// Throughput is one character per cycle unless the receiver stalls, set by the
// single decode, subtract and compare path from input to response register.
// When the receiver stalls, the response register holds its contents and the
// input register holds one more character; req_ready drops only once both are
// occupied. A synchronous reset empties both registers, clears the frame state
// and returns lrc_start to 0 and payload_capacity to 255.
// The csr_ write port sets lrc_start (index 0) and payload_capacity (index 1);
// write it only while the block is idle.

`default_nettype none

module hex_frame_decoder_lrc_check
   import hfd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_char_in,
   input  wire logic       req_frame_end,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_kind,
   output logic [7:0]      rsp_data_byte,
   output logic [2:0]      rsp_status,
   input  wire logic       csr_we,
   input  wire logic       csr_index,
   input  wire logic [7:0] csr_data
);

   // Configuration registers.
   logic [7:0] lrc_start_ff;
   logic [7:0] payload_capacity_ff;

   // Input register.
   logic       in_valid_ff;
   logic [7:0] in_char_ff;
   logic       in_end_ff;

   // Response register.
   logic       out_valid_ff;
   logic       out_kind_ff;
   logic [7:0] out_data_ff;
   status_type out_status_ff;

   logic           advance;
   hfd_result_type result;

   // The held character moves on whenever the response register is free or
   // is being emptied in this cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         lrc_start_ff        <= LrcStartReset;
         payload_capacity_ff <= PayloadCapacityReset;
      end else if (csr_we) begin
         unique case (csr_index)
            CsrLrcStart:        lrc_start_ff        <= csr_data;
            CsrPayloadCapacity: payload_capacity_ff <= csr_data;
            default:            ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_char_ff <= req_char_in;
         in_end_ff  <= req_frame_end;
      end
   end

   hfd_frame_core u_core (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .char_in          (in_char_ff),
      .frame_end        (in_end_ff),
      .lrc_start        (lrc_start_ff),
      .payload_capacity (payload_capacity_ff),
      .result           (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= result.valid;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.valid) begin
         out_kind_ff   <= result.kind;
         out_data_ff   <= result.data_byte;
         out_status_ff <= result.status;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_kind      = out_kind_ff;
   assign rsp_data_byte = out_data_ff;
   assign rsp_status    = out_status_ff;

endmodule

`default_nettype wire

// ===== rtl/hfd_checker.sv =====
`default_nettype none

module hfd_checker
   import hfd_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_kind,
   input wire logic [7:0] rsp_data_byte,
   input wire logic [2:0] rsp_status
);

   // A stalled response keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_data_byte) && $stable(rsp_status))
      else $error("stalled response changed");

   // Nothing comes out in the cycle after reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response right after reset");

   // Data responses carry a zero status field.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KindData |-> rsp_status == StatusOk)
      else $error("data response with nonzero status");

   // Status responses carry a zero data field and a defined code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KindStatus |-> rsp_data_byte == 8'd0
         && rsp_status <= StatusBadDigit)
      else $error("malformed status response");

   // With both registers empty after an idle cycle, a request is always taken.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && $past(!req_valid) && !$past(reset) |-> req_ready)
      else $error("request refused while empty");

endmodule

bind hex_frame_decoder_lrc_check hfd_checker u_hfd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_kind      (rsp_kind),
   .rsp_data_byte (rsp_data_byte),
   .rsp_status    (rsp_status)
);

`default_nettype wire
